[rtl/core/cgps_pkg.sv]
// cgps_pkg: shared widths, register and code names, state type and helpers
// for the chaos-game point shader core. No dependencies.
`timescale 1ns / 1ps

package cgps_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int BYTES_PER_PIXEL = 4;

    localparam int COORD_W    = 12;
    localparam int RADIUS_W   = 11;
    localparam int FW_W       = 13;
    localparam int OFFSET_W   = 26;
    localparam int SHADE_W    = 8;
    localparam int SHADE_MAX  = 255;
    localparam int NORM_W     = 24;                 // 3*r*r
    localparam int DIST_W     = 26;                 // dx*dx + dy*dy
    localparam int LINE_W     = COORD_W + FW_W;     // y * frame width
    localparam int MUL_W      = 13;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = NORM_W + SHADE_W;   // 255 * (R - d)
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int NUM_VTX    = 3;
    localparam int VTX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VA_X    = 3'd0,
        REG_VA_Y    = 3'd1,
        REG_VB_X    = 3'd2,
        REG_VB_Y    = 3'd3,
        REG_VC_X    = 3'd4,
        REG_VC_Y    = 3'd5,
        REG_RADIUS  = 3'd6,
        REG_FRAME_W = 3'd7
    } t_cfg_reg;

    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [VTX_W-1:0] VTX_A = 2'd0;
    localparam logic [VTX_W-1:0] VTX_B = 2'd1;
    localparam logic [VTX_W-1:0] VTX_C = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LINE,
        ST_SQX,
        ST_SQY,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        if (32'(v) > MAX_DIM - 1) begin
            return COORD_W'(MAX_DIM - 1);
        end
        return v;
    endfunction

    function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
        if (32'(v) > MAX_DIM) begin
            return FW_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage

[rtl/core/cgps_shade_div.sv]
// cgps_shade_div: radix-2 restoring divider, 255*diff / norm, one quotient
// bit per cycle. Depends on cgps_pkg.
`timescale 1ns / 1ps

module cgps_shade_div import cgps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NORM_W-1:0]  i_diff,   // R - d, at most R
    input  logic [NORM_W-1:0]  i_norm,   // R, nonzero when started
    output logic               o_done,
    output logic [SHADE_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(SHADE_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_dsh;
    logic [SHADE_W-1:0]  r_q;
    logic [NUM_W:0]      trial;

    assign trial = {1'b0, r_rem} - {1'b0, r_dsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SHADE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient is below 256 since 255*diff <= 255*R
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= NUM_W'(i_diff) * NUM_W'(SHADE_MAX);
            r_dsh <= NUM_W'(i_norm) << (SHADE_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (!trial[NUM_W]) begin
                r_rem <= trial[NUM_W-1:0];
            end
            r_q   <= {r_q[SHADE_W-2:0], ~trial[NUM_W]};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/core/chaos_game_point_shader_core.sv]
// chaos_game_point_shader_core: top level; chaos-game walk, pixel offset and
// per-vertex shades. Depends on cgps_pkg and cgps_shade_div.
// Sequence: a step runs ST_NORM and ST_LINE, then ST_SQX, ST_SQY, ST_PREP,
//   ST_LOAD and, unless the vertex is beyond the shade range, ST_DIV for
//   each vertex in turn, then ST_DONE; a restart only reloads the point.
// Flow: the input stalls until ST_IDLE, so one step is in flight at a time,
//   set by the single shared multiplier and the divider being reused
//   for all three vertices in turn.
// Reset: synchronous, active low; vertices 0, radius and width 1, point and control cleared.
`timescale 1ns / 1ps

module chaos_game_point_shader_core import cgps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [1:0]            i_choice,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_point_x,
    output logic [COORD_W-1:0]    o_point_y,
    output logic [OFFSET_W-1:0]   o_byte_offset,
    output logic [SHADE_W-1:0]    o_shade_a,
    output logic [SHADE_W-1:0]    o_shade_b,
    output logic [SHADE_W-1:0]    o_shade_c,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; the host must write only while no
    // transaction is in flight; the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]  r_vx [NUM_VTX];
    logic [COORD_W-1:0]  r_vy [NUM_VTX];
    logic [RADIUS_W-1:0] r_radius;
    logic [FW_W-1:0]     r_fw;
    t_cfg_reg            cfg_reg;

    assign o_cfg_ready = 1'b1;
    assign cfg_reg     = t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VTX; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_radius <= RADIUS_W'(1);
            r_fw     <= FW_W'(1);
        end else if (i_cfg_valid) begin
            unique case (cfg_reg)
                REG_VA_X:    r_vx[0]  <= i_cfg_data[COORD_W-1:0];
                REG_VA_Y:    r_vy[0]  <= i_cfg_data[COORD_W-1:0];
                REG_VB_X:    r_vx[1]  <= i_cfg_data[COORD_W-1:0];
                REG_VB_Y:    r_vy[1]  <= i_cfg_data[COORD_W-1:0];
                REG_VC_X:    r_vx[2]  <= i_cfg_data[COORD_W-1:0];
                REG_VC_Y:    r_vy[2]  <= i_cfg_data[COORD_W-1:0];
                REG_RADIUS:  r_radius <= i_cfg_data[RADIUS_W-1:0];
                REG_FRAME_W: r_fw     <= i_cfg_data[FW_W-1:0];
                default:     r_fw     <= r_fw;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [COORD_W-1:0]  r_cur_x, r_cur_y;      // walking point
    logic [VTX_W-1:0]    r_vtx;                 // vertex being shaded
    logic [NORM_W-1:0]   r_norm;                // R = 3*r*r
    logic [LINE_W-1:0]   r_line;                // y * frame width
    logic [DIST_W-1:0]   r_dsq;                 // dx*dx
    logic [DIST_W-1:0]   r_dist;                // dx*dx + dy*dy
    logic [NORM_W-1:0]   r_diff;                // R - d
    logic                r_far;                 // d >= R, shade saturates at 0
    logic [SHADE_W-1:0]  r_shade [NUM_VTX];

    logic                r_out_valid;
    logic [COORD_W-1:0]  r_out_x, r_out_y;
    logic [OFFSET_W-1:0] r_out_off;
    logic [SHADE_W-1:0]  r_out_shade [NUM_VTX];

    logic                in_accept;
    logic                out_free;
    logic                last_vtx;
    logic                div_start;
    logic                div_done;
    logic [SHADE_W-1:0]  div_quot;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_vtx  = (r_vtx == VTX_C);

    // ------------------------------------------------------------------
    // Step: move halfway toward the chosen vertex, rounding up.
    // Choice three is handled as vertex C.
    // ------------------------------------------------------------------
    logic [VTX_W-1:0]   sel_in;
    logic [COORD_W-1:0] tgt_x, tgt_y;
    logic [COORD_W:0]   sum_x, sum_y;

    assign sel_in = (i_choice == VTX_A) ? VTX_A :
                    (i_choice == VTX_B) ? VTX_B : VTX_C;
    assign tgt_x  = clamp_coord(r_vx[sel_in]);
    assign tgt_y  = clamp_coord(r_vy[sel_in]);
    assign sum_x  = {1'b0, r_cur_x} + {1'b0, tgt_x} + (COORD_W+1)'(1);
    assign sum_y  = {1'b0, r_cur_y} + {1'b0, tgt_y} + (COORD_W+1)'(1);

    // ------------------------------------------------------------------
    // Shared multiplier and its operand select
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] vert_x, vert_y;
    logic [COORD_W-1:0] abs_dx, abs_dy;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;

    assign vert_x = clamp_coord(r_vx[r_vtx]);
    assign vert_y = clamp_coord(r_vy[r_vtx]);
    assign abs_dx = (r_cur_x >= vert_x) ? r_cur_x - vert_x : vert_x - r_cur_x;
    assign abs_dy = (r_cur_y >= vert_y) ? r_cur_y - vert_y : vert_y - r_cur_y;
    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);

    // distance test: R - d, negative or zero means saturate
    logic [DIST_W:0] diff_full;
    assign diff_full = (DIST_W+1)'(r_norm) - {1'b0, r_dist};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_op == OP_STEP) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: n_state = ST_LINE;
            ST_LINE: n_state = ST_SQX;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_PREP;
            ST_PREP: n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_far) begin
                    n_state = last_vtx ? ST_DONE : ST_SQX;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = last_vtx ? ST_DONE : ST_SQX;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state) inside
            ST_IDLE: o_in_stall = 1'b0;
            ST_NORM: begin
                mul_a = MUL_W'(r_radius);
                mul_b = MUL_W'(r_radius);
            end
            ST_LINE: begin
                mul_a = MUL_W'(r_cur_y);
                mul_b = MUL_W'(clamp_width(r_fw));
            end
            ST_SQX: begin
                mul_a = MUL_W'(abs_dx);
                mul_b = MUL_W'(abs_dx);
            end
            ST_SQY: begin
                mul_a = MUL_W'(abs_dy);
                mul_b = MUL_W'(abs_dy);
            end
            ST_LOAD: div_start = !r_far;
            ST_PREP, ST_DIV, ST_DONE: o_in_stall = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Walking point (control state, reset to the origin)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (in_accept) begin
            if (i_op == OP_RESTART) begin
                r_cur_x <= clamp_coord(r_vx[0]);
                r_cur_y <= clamp_coord(r_vy[0]);
            end else begin
                r_cur_x <= sum_x[COORD_W:1];
                r_cur_y <= sum_y[COORD_W:1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_vtx <= VTX_A;
            ST_NORM: r_norm <= NORM_W'(prod) + NORM_W'({prod, 1'b0});
            ST_LINE: r_line <= LINE_W'(prod);
            ST_SQX:  r_dsq  <= DIST_W'(prod);
            ST_SQY:  r_dist <= r_dsq + DIST_W'(prod);
            ST_PREP: begin
                // R of zero always lands here, so no division by zero
                r_far  <= diff_full[DIST_W] || (diff_full == '0);
                r_diff <= NORM_W'(diff_full);
            end
            ST_LOAD: begin
                if (r_far) begin
                    r_shade[r_vtx] <= '0;
                    r_vtx          <= r_vtx + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_shade[r_vtx] <= div_quot;
                    r_vtx          <= r_vtx + 1'b1;
                end
            end
            default: r_vtx <= r_vtx;
        endcase
    end

    cgps_shade_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (r_diff),
        .i_norm  (r_norm),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Result register: holds one transaction; the input side may already
    // take the next item while it waits.
    // ------------------------------------------------------------------
    logic               out_load;
    logic [LINE_W-1:0]  pix_index;

    assign out_load  = (r_state == ST_DONE) && out_free;
    assign pix_index = r_line + LINE_W'(r_cur_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x   <= r_cur_x;
            r_out_y   <= r_cur_y;
            // wraps to the offset width
            r_out_off <= OFFSET_W'(OFFSET_W'(pix_index) * OFFSET_W'(BYTES_PER_PIXEL));
            for (int k = 0; k < NUM_VTX; k++) begin
                r_out_shade[k] <= r_shade[k];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_byte_offset = r_out_off;
    assign o_shade_a     = r_out_shade[0];
    assign o_shade_b     = r_out_shade[1];
    assign o_shade_c     = r_out_shade[2];

endmodule

[verif/chaos_game_point_shader_core_tb.sv]
// chaos_game_point_shader_core_tb: self-checking testbench for the chaos-game
// point shader core. Depends on cgps_pkg and chaos_game_point_shader_core.
`timescale 1ns / 1ps

module chaos_game_point_shader_core_tb;
    import cgps_pkg::*;

    // choice code 3 has no vertex of its own; the block folds it onto C
    localparam logic [VTX_W-1:0] VTX_C_ALIAS = 2'd3;

    localparam int  SETTLE      = 60;        // settle time after the last owed pixel
    localparam int  LONG_HOLD   = 500;       // receiver hold-off, in cycles
    localparam int  N_PHASES    = 8;
    localparam int  PHASE_ITEMS = 212;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  PHASE_KIND [N_PHASES] = '{0, 0, 1, 2, 0, 1, 0, 2};

    // one pixel write: the walked point, its buffer offset and three shades
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [OFFSET_W-1:0] offset;
        logic [SHADE_W-1:0]  shade_a;
        logic [SHADE_W-1:0]  shade_b;
        logic [SHADE_W-1:0]  shade_c;
    } t_pixel;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  op;
        logic [VTX_W-1:0]      choice;
        t_cfg_reg              idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;    // exp below is used as is
        t_pixel                exp;
    } t_dir_row;

    // Reset setting: all vertices at 0, r = 1, width 1. The point stays at
    // the origin, d = 0 < 3, so every shade is full.
    localparam t_pixel ORIGIN_PIX = '{12'd0, 12'd0, 26'd0, 8'd255, 8'd255, 8'd255};
    // Far corner with the width clamped to 4096 and r = 0: shades all zero.
    localparam t_pixel CORNER_PIX = '{12'd4095, 12'd4095, 26'd67108860, 8'd0, 8'd0, 8'd0};
    localparam t_pixel NO_PIX     = '0;

    localparam t_dir_row DIR_TABLE [33] = '{
        // straight out of reset
        '{ROW_ITEM, OP_STEP,    VTX_A,       REG_VA_X,    13'd0,    1'b1, ORIGIN_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_C_ALIAS, REG_VA_X,    13'd0,    1'b1, ORIGIN_PIX},
        '{ROW_ITEM, OP_RESTART, VTX_A,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_B,       REG_VA_X,    13'd0,    1'b1, ORIGIN_PIX},
        // corners, zero radius, width above the clamp
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_X,    13'd4095, 1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_Y,    13'd4095, 1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VC_X,    13'd4095, 1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_RADIUS,  13'd0,    1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_FRAME_W, 13'd8191, 1'b0, NO_PIX},
        '{ROW_ITEM, OP_RESTART, VTX_A,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_A,       REG_VA_X,    13'd0,    1'b1, CORNER_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_B,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_C,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        // largest radius, zero width
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_RADIUS,  13'd2047, 1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_FRAME_W, 13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_A,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_C_ALIAS, REG_VA_X,    13'd0,    1'b0, NO_PIX},
        // tiny radius: point far from every vertex
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_RADIUS,  13'd1,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_B,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        // ordinary triangle
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_X,    13'd100,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_Y,    13'd200,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VB_X,    13'd400,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VB_Y,    13'd700,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VC_Y,    13'd900,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_RADIUS,  13'd300,  1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_FRAME_W, 13'd640,  1'b0, NO_PIX},
        // vertex A moved after a restart: the point keeps the old A
        '{ROW_ITEM, OP_RESTART, VTX_A,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_X,    13'd3000, 1'b0, NO_PIX},
        '{ROW_CFG,  OP_STEP,    VTX_A,       REG_VA_Y,    13'd10,   1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_A,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_C,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_B,       REG_VA_X,    13'd0,    1'b0, NO_PIX},
        '{ROW_ITEM, OP_STEP,    VTX_C_ALIAS, REG_VA_X,    13'd0,    1'b0, NO_PIX}
    };

    // DUT ports; every input starts at a known value
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_op        = OP_STEP;
    logic [1:0]            i_choice    = VTX_A;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COORD_W-1:0]    o_point_x;
    logic [COORD_W-1:0]    o_point_y;
    logic [OFFSET_W-1:0]   o_byte_offset;
    logic [SHADE_W-1:0]    o_shade_a;
    logic [SHADE_W-1:0]    o_shade_b;
    logic [SHADE_W-1:0]    o_shade_c;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_VA_X;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow of the block: registers and the walking point
    logic [COORD_W-1:0]  vert_x [NUM_VTX];
    logic [COORD_W-1:0]  vert_y [NUM_VTX];
    logic [RADIUS_W-1:0] radius_reg;
    logic [FW_W-1:0]     width_reg;
    logic [COORD_W-1:0]  walk_x;
    logic [COORD_W-1:0]  walk_y;

    t_pixel pixel_q [$];          // pixel writes still owed by the block
    int     mismatches       = 0;
    bit     work_since_idle  = 1'b0;
    bit     sender_quiet     = 1'b0;
    bit     receiver_quiet   = 1'b0;
    bit     hold_off_req     = 1'b0;
    longint cycles           = 0;

    chaos_game_point_shader_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Runaway guard: far above the slowest legal run.
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Shade toward vertex k: floor(255*(R-d)/R), zero once d reaches R.
    // R = 0 falls into the d >= R branch, so no division by zero.
    function automatic logic [SHADE_W-1:0] shade_toward(input int k,
                                                        input logic [COORD_W-1:0] px,
                                                        input logic [COORD_W-1:0] py,
                                                        input longint unsigned norm);
        longint          dx;
        longint          dy;
        longint unsigned dsq;
        dx  = longint'(px) - longint'(vert_x[k]);
        dy  = longint'(py) - longint'(vert_y[k]);
        dsq = longint'(dx * dx + dy * dy);
        if (dsq >= norm) begin
            return '0;
        end
        return SHADE_W'((SHADE_MAX * (norm - dsq)) / norm);
    endfunction

    // Moves the shadow point for one input transaction and builds the pixel
    // write it causes. Vertex registers are 12 bits wide, so the coordinate
    // clamp to MAX_DIM-1 can never bite here.
    task automatic advance_point(input logic op, input logic [VTX_W-1:0] choice,
                                 output bit emits, output t_pixel pix);
        int              vsel;
        longint unsigned fw;
        longint unsigned norm;
        longint unsigned off;
        emits = 1'b0;
        pix   = '0;
        if (op == OP_RESTART) begin
            walk_x = vert_x[0];
            walk_y = vert_y[0];
            return;
        end
        vsel   = (choice > VTX_C) ? 2 : int'(choice);
        walk_x = COORD_W'((32'(walk_x) + 32'(vert_x[vsel]) + 1) >> 1);
        walk_y = COORD_W'((32'(walk_y) + 32'(vert_y[vsel]) + 1) >> 1);
        fw     = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        off    = (longint'(walk_y) * fw + walk_x) * BYTES_PER_PIXEL;
        norm   = 3 * longint'(radius_reg) * longint'(radius_reg);
        emits       = 1'b1;
        pix.x       = walk_x;
        pix.y       = walk_y;
        pix.offset  = OFFSET_W'(off);
        pix.shade_a = shade_toward(0, walk_x, walk_y, norm);
        pix.shade_b = shade_toward(1, walk_x, walk_y, norm);
        pix.shade_c = shade_toward(2, walk_x, walk_y, norm);
    endtask

    // Offers one input transaction, with a random lead-in gap, and books the
    // pixel write it should produce. A typed row overrides the prediction.
    task automatic send_item(input logic op, input logic [VTX_W-1:0] choice,
                             input logic typed, input t_pixel typed_pix);
        int     gap;
        bit     emits;
        t_pixel pix;
        gap = 0;
        if (!sender_quiet && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_choice   <= choice;
        do @(posedge i_clk); while (o_in_stall);
        advance_point(op, choice, emits, pix);
        if (emits) begin
            pixel_q.push_back(typed ? typed_pix : pix);
        end
        work_since_idle = 1'b1;
    endtask

    // Stop offering, wait for every owed pixel, then let a trailing restart
    // finish before anything else touches the block.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        if (work_since_idle) begin
            repeat (SETTLE) @(posedge i_clk);
            work_since_idle = 1'b0;
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_VA_X:    vert_x[0]  = data[COORD_W-1:0];
            REG_VA_Y:    vert_y[0]  = data[COORD_W-1:0];
            REG_VB_X:    vert_x[1]  = data[COORD_W-1:0];
            REG_VB_Y:    vert_y[1]  = data[COORD_W-1:0];
            REG_VC_X:    vert_x[2]  = data[COORD_W-1:0];
            REG_VC_Y:    vert_y[2]  = data[COORD_W-1:0];
            REG_RADIUS:  radius_reg = data[RADIUS_W-1:0];
            REG_FRAME_W: width_reg  = data[FW_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side back-pressure. Normally short random runs of stall/go with
    // the odd long run; on request one long hold-off so the block backs up
    // into its input channel.
    initial begin
        int run;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (receiver_quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
                repeat (run - 1) @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Result checker: each accepted transaction against the oldest owed pixel.
    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got x=%0d y=%0d",
                         $time, o_point_x, o_point_y);
            end else begin
                exp_pix = pixel_q.pop_front();
                check_field("point_x",     exp_pix.x,       o_point_x);
                check_field("point_y",     exp_pix.y,       o_point_y);
                check_field("byte_offset", exp_pix.offset,  o_byte_offset);
                check_field("shade_a",     exp_pix.shade_a, o_shade_a);
                check_field("shade_b",     exp_pix.shade_b, o_shade_b);
                check_field("shade_c",     exp_pix.shade_c, o_shade_c);
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases, each
    // behind a fresh register setting.
    initial begin
        int                    r;
        int                    h;
        int                    half;
        int                    cx;
        int                    cy;
        logic                  op;
        logic [VTX_W-1:0]      choice;
        logic [CFG_DATA_W-1:0] setting [8];

        foreach (vert_x[k]) begin
            vert_x[k] = '0;
            vert_y[k] = '0;
        end
        radius_reg = RADIUS_W'(1);
        width_reg  = FW_W'(1);
        walk_x     = '0;
        walk_y     = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TABLE[i]) begin
            if (DIR_TABLE[i].kind == ROW_CFG) begin
                write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
            end else begin
                send_item(DIR_TABLE[i].op, DIR_TABLE[i].choice,
                          DIR_TABLE[i].typed, DIR_TABLE[i].exp);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (PHASE_KIND[p])
                0: begin
                    // Near-equilateral triangle around (cx, cy): the walk
                    // stays inside it, so shades spread over the full range.
                    r    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047)
                                                       : $urandom_range(1, 400);
                    h    = (r * 866) / 1000;
                    half = r / 2;
                    cx   = $urandom_range(h, 4095 - h);
                    cy   = $urandom_range(r, 4095 - half);
                    setting[0] = CFG_DATA_W'(cx);
                    setting[1] = CFG_DATA_W'(cy - r);
                    setting[2] = CFG_DATA_W'(cx - h);
                    setting[3] = CFG_DATA_W'(cy + half);
                    setting[4] = CFG_DATA_W'(cx + h);
                    setting[5] = CFG_DATA_W'(cy + half);
                    setting[6] = CFG_DATA_W'(r);
                    setting[7] = $urandom_range(0, 1) ? CFG_DATA_W'(640)
                                                      : CFG_DATA_W'($urandom_range(1, 4096));
                end
                1: begin
                    // raw data, upper bits included
                    foreach (setting[j]) setting[j] = CFG_DATA_W'($urandom_range(0, 8191));
                end
                default: begin
                    // corners and range ends
                    for (int j = 0; j < 6; j++) begin
                        setting[j] = $urandom_range(0, 1) ? CFG_DATA_W'(4095) : '0;
                    end
                    case ($urandom_range(0, 2))
                        0:       setting[6] = CFG_DATA_W'(0);
                        1:       setting[6] = CFG_DATA_W'(1);
                        default: setting[6] = CFG_DATA_W'(2047);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       setting[7] = CFG_DATA_W'(0);
                        1:       setting[7] = CFG_DATA_W'(1);
                        2:       setting[7] = CFG_DATA_W'(4096);
                        default: setting[7] = CFG_DATA_W'(8191);
                    endcase
                end
            endcase
            foreach (setting[j]) write_reg(t_cfg_reg'(j), setting[j]);

            // first phase: long receiver hold-off while the sender keeps
            // pushing; third phase: both sides run flat out
            sender_quiet   = (p == 0) || (p == 2);
            receiver_quiet = (p == 2);
            hold_off_req   = (p == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    wait_idle();
                end
                op     = ($urandom_range(0, 9) == 0) ? OP_RESTART : OP_STEP;
                choice = VTX_W'($urandom_range(0, 3));
                send_item(op, choice, 1'b0, NO_PIX);
            end
        end

        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[chaos_game_point_shader_core.f]
rtl/core/cgps_pkg.sv
rtl/core/cgps_shade_div.sv
rtl/core/chaos_game_point_shader_core.sv
verif/chaos_game_point_shader_core_tb.sv
